/* sv/pfpe_pkg.sv */
// Shared types and constants for the page-layout framebuffer pixel engine.
package pfpe_pkg;

  localparam int UB_W        = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_FILL    = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_REFRESH = 2'd3;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_OFFSET   = 3'd2;
  localparam logic [2:0] REG_MIRROR_X     = 3'd3;
  localparam logic [2:0] REG_MIRROR_Y     = 3'd4;

  localparam logic [7:0] FILL_ON  = 8'hFF;
  localparam logic [7:0] FILL_OFF = 8'h00;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_FILL,
    CMD_READ,
    CMD_REFRESH,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] col;
    logic [3:0] page;
    logic [2:0] bitpos;
    logic       on;
    logic [9:0] index;
  } cmd_t;

  typedef struct packed {
    logic [7:0]      width;
    logic [6:0]      height;
    logic [UB_W-1:0] bytes;
  } geom_t;

  typedef struct packed {
    logic [7:0] frame_width;
    logic [6:0] frame_height;
    logic [5:0] row_offset;
    logic       mirror_x;
    logic       mirror_y;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOAD,
    BK_STORE,
    BK_FILL,
    BK_DONE
  } back_state_t;

endpackage

/* sv/pfpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/pfpe_queue.sv */
// Two-entry command queue between the front and back parts.
module pfpe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfpe_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output pfpe_pkg::cmd_t  head,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = $clog2(pfpe_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pfpe_pkg::QUEUE_DEPTH + 1);

  pfpe_pkg::cmd_t   entries [pfpe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(pfpe_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pfpe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pfpe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* sv/pfpe_front.sv */
// Front part: accepts requests, checks ranges, maps coordinates and classifies.
module pfpe_front #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  pfpe_pkg::cfg_t        cfg,
  input  logic                  queue_full,
  input  logic                  clearing,
  output logic                  push,
  output pfpe_pkg::cmd_t        cmd,
  output pfpe_pkg::geom_t       geom
);

  logic [7:0]  w;
  logic [6:0]  h_raw;
  logic [6:0]  h;
  logic [7:0]  x;
  logic [7:0]  y;
  logic        on;
  logic [9:0]  idx;
  logic [7:0]  xm;
  logic [6:0]  ym;
  logic [11:0] rem;
  logic [11:0] hk;

  assign x   = s_axis_tdata[7:0];
  assign y   = s_axis_tdata[15:8];
  assign on  = s_axis_tdata[16];
  assign idx = s_axis_tdata[26:17];

  always_comb begin
    if (9'(cfg.frame_width) > 9'(MAX_WIDTH)) begin
      w = 8'(MAX_WIDTH);
    end else begin
      w = cfg.frame_width;
    end
    if (9'(cfg.frame_height) > 9'(MAX_HEIGHT)) begin
      h_raw = 7'(MAX_HEIGHT);
    end else begin
      h_raw = cfg.frame_height;
    end
    h = {h_raw[6:3], 3'b000};
  end

  assign geom.width  = w;
  assign geom.height = h;
  assign geom.bytes  = pfpe_pkg::UB_W'(w) * pfpe_pkg::UB_W'(h[6:3]);

  // mirror, offset and wrap the row modulo height by shifted compare-subtract
  always_comb begin
    hk  = '0;
    xm  = cfg.mirror_x ? (w - 8'd1 - x) : x;
    ym  = cfg.mirror_y ? (h - 7'd1 - y[6:0]) : y[6:0];
    rem = 12'(ym) + 12'(cfg.row_offset);
    for (int k = 4; k >= 0; k--) begin
      hk = 12'(h) << k;
      if (rem >= hk) begin
        rem = rem - hk;
      end
    end
  end

  always_comb begin
    cmd.kind   = pfpe_pkg::CMD_REFRESH;
    cmd.col    = xm;
    cmd.page   = rem[6:3];
    cmd.bitpos = rem[2:0];
    cmd.on     = on;
    cmd.index  = idx;
    unique case (s_axis_tuser)
      pfpe_pkg::REQ_WRITE: begin
        if ((x >= w) || (y >= 8'(h))) begin
          cmd.kind = pfpe_pkg::CMD_REJECT;
        end else begin
          cmd.kind = pfpe_pkg::CMD_WRITE;
        end
      end
      pfpe_pkg::REQ_FILL: begin
        cmd.kind = pfpe_pkg::CMD_FILL;
      end
      pfpe_pkg::REQ_READ: begin
        if (pfpe_pkg::UB_W'(idx) >= geom.bytes) begin
          cmd.kind = pfpe_pkg::CMD_REJECT;
        end else begin
          cmd.kind = pfpe_pkg::CMD_READ;
        end
      end
      pfpe_pkg::REQ_REFRESH: begin
        cmd.kind = pfpe_pkg::CMD_REFRESH;
      end
      default: begin
        cmd.kind = pfpe_pkg::CMD_REFRESH;
      end
    endcase
  end

  assign s_axis_tready = !queue_full && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;

endmodule

/* sv/pfpe_back.sv */
// Back part: clears the store, runs read-modify-write, fill and read, holds results.
module pfpe_back #(
  parameter int RAM_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pfpe_pkg::cmd_t           head,
  input  logic                     queue_empty,
  output logic                     pop,
  input  pfpe_pkg::geom_t          geom,
  output logic                     clearing,
  output logic                     ram_we,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]               ram_rdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [15:0]              m_axis_tdata
);

  localparam int ADDR_W = $clog2(RAM_DEPTH);

  pfpe_pkg::back_state_t state;
  pfpe_pkg::back_state_t state_next;
  pfpe_pkg::cmd_t        cur;
  logic [ADDR_W-1:0]     cnt;
  logic [ADDR_W-1:0]     addr;
  logic                  dirty;
  logic                  dirty_next;
  logic                  out_status;
  logic [7:0]            out_byte;
  logic                  out_pending;
  logic                  load_out;
  logic [7:0]            mask;
  logic [pfpe_pkg::UB_W-1:0] pix_addr;
  logic [pfpe_pkg::UB_W-1:0] rd_index;

  assign mask     = 8'd1 << cur.bitpos;
  assign pix_addr = pfpe_pkg::UB_W'(head.col)
                  + pfpe_pkg::UB_W'(head.page) * pfpe_pkg::UB_W'(geom.width);
  assign rd_index = pfpe_pkg::UB_W'(head.index);
  assign ram_raddr = addr;
  assign clearing  = (state == pfpe_pkg::BK_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      pfpe_pkg::BK_CLEAR: begin
        if (cnt == ADDR_W'(RAM_DEPTH - 1)) begin
          state_next = pfpe_pkg::BK_IDLE;
        end
      end
      pfpe_pkg::BK_IDLE: begin
        if (!queue_empty) begin
          unique case (head.kind)
            pfpe_pkg::CMD_WRITE, pfpe_pkg::CMD_READ: state_next = pfpe_pkg::BK_LOAD;
            pfpe_pkg::CMD_FILL: begin
              state_next = (geom.bytes == '0) ? pfpe_pkg::BK_DONE : pfpe_pkg::BK_FILL;
            end
            default: state_next = pfpe_pkg::BK_DONE;
          endcase
        end
      end
      pfpe_pkg::BK_LOAD: begin
        state_next = (cur.kind == pfpe_pkg::CMD_WRITE) ? pfpe_pkg::BK_STORE
                                                       : pfpe_pkg::BK_DONE;
      end
      pfpe_pkg::BK_STORE: state_next = pfpe_pkg::BK_DONE;
      pfpe_pkg::BK_FILL: begin
        if (pfpe_pkg::UB_W'(cnt) == geom.bytes - 1'b1) begin
          state_next = pfpe_pkg::BK_DONE;
        end
      end
      pfpe_pkg::BK_DONE: begin
        if (load_out) begin
          state_next = pfpe_pkg::BK_IDLE;
        end
      end
      default: state_next = pfpe_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = pfpe_pkg::FILL_OFF;
    load_out  = 1'b0;
    unique case (state)
      pfpe_pkg::BK_CLEAR: begin
        ram_we = 1'b1;
      end
      pfpe_pkg::BK_IDLE: begin
        pop = !queue_empty;
      end
      pfpe_pkg::BK_LOAD: begin
        ram_we = 1'b0;
      end
      pfpe_pkg::BK_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = addr;
        ram_wdata = cur.on ? (ram_rdata | mask) : (ram_rdata & ~mask);
      end
      pfpe_pkg::BK_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = cur.on ? pfpe_pkg::FILL_ON : pfpe_pkg::FILL_OFF;
      end
      pfpe_pkg::BK_DONE: begin
        load_out = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    dirty_next = dirty;
    if ((cur.kind == pfpe_pkg::CMD_WRITE) || (cur.kind == pfpe_pkg::CMD_FILL)) begin
      dirty_next = 1'b1;
    end else if (cur.kind == pfpe_pkg::CMD_REFRESH) begin
      dirty_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pfpe_pkg::BK_CLEAR;
      cnt           <= '0;
      dirty         <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == pfpe_pkg::BK_CLEAR) || (state == pfpe_pkg::BK_FILL)) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        dirty         <= dirty_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      addr <= (head.kind == pfpe_pkg::CMD_READ) ? rd_index[ADDR_W-1:0]
                                               : pix_addr[ADDR_W-1:0];
    end
    if (load_out) begin
      out_status  <= (cur.kind == pfpe_pkg::CMD_REJECT);
      out_byte    <= (cur.kind == pfpe_pkg::CMD_READ) ? ram_rdata : 8'd0;
      out_pending <= dirty_next;
    end
  end

  assign m_axis_tdata = {6'd0, out_pending, out_byte, out_status};

endmodule

/* sv/page_framebuffer_pixel_engine.sv */
// Monochrome page-layout framebuffer: top level with configuration registers.
//
// Requests enter on s_axis (tuser = request kind, tdata = pixel fields) and
// each gives exactly one word on m_axis (status, read byte, pending flag).
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// The front part checks ranges and maps x, y (mirror, row offset, wrap modulo
// height) in the accept cycle and places a command into a two-entry queue.
// The back part runs one command at a time against a single frame RAM with a
// registered read port, which sets the steps per request:
//   refresh or rejected request: idle, then done
//   byte read: idle, load, done; pixel write (read-modify-write): idle, load, store, done
//   fill: idle, then one byte written per cycle over the bytes in use, then done
// After reset the back part clears the whole frame RAM, one byte per cycle
// (MAX_WIDTH clipped to 255 times MAX_HEIGHT rounded down to a multiple of 8
// and clipped to 120, divided by 8: 1024 bytes at default), and s_axis_tready
// stays low meanwhile; the pending flag starts set. A stalled receiver holds
// the result in the output register; requests keep entering until the queue fills.
module page_framebuffer_pixel_engine #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel_x, pixel_y, pixel_on, byte_index, zero pad
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status, read_byte, pending, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CAP_W     = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
  localparam int CAP_H8    = (MAX_HEIGHT / 8) * 8;
  localparam int CAP_H     = (CAP_H8 < 120) ? CAP_H8 : 120;
  localparam int RAM_DEPTH = CAP_W * CAP_H / 8;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  pfpe_pkg::cfg_t  cfg;
  pfpe_pkg::cmd_t  push_cmd;
  pfpe_pkg::cmd_t  head;
  pfpe_pkg::geom_t geom;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;
  logic            clearing;
  logic            ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 8'd128;
      cfg.frame_height <= 7'd64;
      cfg.row_offset   <= 6'd0;
      cfg.mirror_x     <= 1'b0;
      cfg.mirror_y     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfpe_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        pfpe_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[6:0];
        pfpe_pkg::REG_ROW_OFFSET:   cfg.row_offset   <= cfg_data[5:0];
        pfpe_pkg::REG_MIRROR_X:     cfg.mirror_x     <= cfg_data[0];
        pfpe_pkg::REG_MIRROR_Y:     cfg.mirror_y     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfpe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg           (cfg),
    .queue_full    (q_full),
    .clearing      (clearing),
    .push          (push),
    .cmd           (push_cmd),
    .geom          (geom)
  );

  pfpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pfpe_back #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .queue_empty   (q_empty),
    .pop           (pop),
    .geom          (geom),
    .clearing      (clearing),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pfpe_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("queue overflow");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready) else $error("request accepted during clear");

  a_reject_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[8:1] == 8'd0))
    else $error("rejected request carries data");

endmodule
